// ----- rtl/core/forward_box_blur_rgb_defines.svh -----
// Assertion macros for the box blur block
`ifndef FORWARD_BOX_BLUR_RGB_DEFINES_SVH
`define FORWARD_BOX_BLUR_RGB_DEFINES_SVH

// hold a property that implies in the same cycle
`define FBB_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// hold a property that implies in the next cycle
`define FBB_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ----- rtl/core/fbb_pkg.sv -----
`default_nettype none
package fbb_pkg;
   localparam int MAX_KERNEL = 15;
   localparam int MAX_WIDTH  = 2048;
   localparam int MIN_KERNEL = 3;
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int SLOT_W     = $clog2(MAX_KERNEL);
   localparam int RS_AW      = SLOT_W + XW;
   localparam int RS_DEPTH   = MAX_KERNEL * MAX_WIDTH;
   localparam int CSUM_W     = 12;
   localparam int WSUM_W     = 16;
   localparam int CNT_W      = 8;
   localparam int STEP_W     = $clog2(WSUM_W);
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_KERNEL = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SUM,
      BK_DIV,
      BK_HOLD
   } back_state_type;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } req_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      req_type             pix;
      logic [XW-1:0]       x;
      logic [XW-1:0]       xk;
      logic [SLOT_W-1:0]   slot;
      logic                row_first;
      logic                row_ge_k;
      logic                col_first;
      logic                col_ge_k;
      logic [CNT_W-1:0]    count;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;
endpackage
`default_nettype wire

// ----- rtl/core/fbb_front.sv -----
`default_nettype none
module fbb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fbb_pkg::req_type      req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  fbb_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_data,
   input  fbb_pkg::q_stat_type   q_stat,
   output logic                  cmd_push,
   output fbb_pkg::cmd_type      cmd
);
   import fbb_pkg::*;

   logic [11:0]       width_ff, width_in;
   logic [15:0]       height_ff, height_in;
   logic [3:0]        kernel_ff, kernel_in;
   logic [XW-1:0]     col_ff, col_in;
   logic [15:0]       row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [11:0] w_eff, col_ext, x_ext;
   logic [15:0] h_eff;
   logic [3:0]  k_eff, cols, rows;
   logic        col_last, row_last, col_ge_k, row_ge_k;

   assign csr_ready = 1'b1;
   assign req_stall = q_stat.full;
   assign cmd_push  = req_valid && !q_stat.full;

   always_comb begin
      w_eff = width_ff;
      if (width_ff == 12'd0) w_eff = 12'd1;
      else if (width_ff > 12'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
      h_eff    = (height_ff == 16'd0) ? 16'd1 : height_ff;
      k_eff    = (kernel_ff < 4'(MIN_KERNEL)) ? 4'(MIN_KERNEL) : kernel_ff;
      col_ext  = {1'b0, col_ff};
      col_last = (col_ext == w_eff - 12'd1);
      row_last = (row_ff == h_eff - 16'd1);
      col_ge_k = (col_ext >= {8'd0, k_eff});
      row_ge_k = (row_ff >= {12'd0, k_eff});
      x_ext    = w_eff - 12'd1 - col_ext;
      cols     = col_ge_k ? k_eff : 4'(col_ext + 12'd1);
      rows     = row_ge_k ? k_eff : 4'(row_ff + 16'd1);

      cmd.pix       = req_data;
      cmd.x         = x_ext[XW-1:0];
      cmd.xk        = XW'(x_ext + {8'd0, k_eff});
      cmd.slot      = slot_ff;
      cmd.row_first = (row_ff == 16'd0);
      cmd.row_ge_k  = row_ge_k;
      cmd.col_first = (col_ff == '0);
      cmd.col_ge_k  = col_ge_k;
      cmd.count     = CNT_W'({4'd0, cols} * {4'd0, rows});
      cmd.last      = col_last && row_last;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      kernel_in = kernel_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      slot_in   = slot_ff;
      if (cmd_push) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = 16'd0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + 16'd1;
               slot_in = (slot_ff == SLOT_W'(k_eff - 4'd1)) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_data[11:0];
            CSR_HEIGHT: height_in = csr_data;
            CSR_KERNEL: kernel_in = csr_data[3:0];
            default: ;
         endcase
         if (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT ||
             csr_index == CSR_KERNEL) begin
            col_in  = '0;
            row_in  = 16'd0;
            slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd1;
         height_ff <= 16'd1;
         kernel_ff <= 4'(MIN_KERNEL);
         col_ff    <= '0;
         row_ff    <= 16'd0;
         slot_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         kernel_ff <= kernel_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         slot_ff   <= slot_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/fbb_queue.sv -----
`default_nettype none
module fbb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fbb_pkg::cmd_type    push_data,
   input  logic                pop,
   output fbb_pkg::cmd_type    head,
   output fbb_pkg::q_stat_type stat
);
   import fbb_pkg::*;

   cmd_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign stat.full  = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head       = mem_ff[rd_ff];
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/fbb_back.sv -----
`default_nettype none
module fbb_back (
   input  logic                clock,
   input  logic                reset,
   input  fbb_pkg::cmd_type    head,
   input  fbb_pkg::q_stat_type q_stat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fbb_pkg::rsp_type    rsp_data
);
   import fbb_pkg::*;

   logic [23:0]          row_store [RS_DEPTH];
   logic [3*CSUM_W-1:0]  column_sums [MAX_WIDTH];

   back_state_type       state_ff, state_in;
   cmd_type              cur_ff;
   logic [23:0]          rs_rd_ff;
   logic [3*CSUM_W-1:0]  cs_x_ff, cs_xk_ff;
   logic [WSUM_W-1:0]    wsum_ff [3];
   logic [WSUM_W-1:0]    quo_ff [3];
   logic [7:0]           rem_ff [3];
   logic [STEP_W-1:0]    step_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 rd_en, load_sum, div_step, load_rsp;
   logic [7:0]           pix_ch [3];
   logic [CSUM_W-1:0]    new_cs [3];
   logic [WSUM_W-1:0]    new_ws [3];
   logic [WSUM_W-1:0]    quo_in [3];
   logic [7:0]           rem_in [3];
   logic [8:0]           rem_sh [3];
   logic [CSUM_W-1:0]    cs_old [3];
   logic [7:0]           rs_sub [3];
   logic [WSUM_W-1:0]    ws_old [3];
   logic [CSUM_W-1:0]    ws_sub [3];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      rd_en    = 1'b0;
      load_sum = 1'b0;
      div_step = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               state_in = BK_SUM;
            end
         end
         BK_SUM: begin
            load_sum = 1'b1;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            div_step = 1'b1;
            if (step_ff == STEP_W'(WSUM_W - 1)) state_in = BK_HOLD;
         end
         BK_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pix_ch[0] = cur_ff.pix.blue_in;
      pix_ch[1] = cur_ff.pix.green_in;
      pix_ch[2] = cur_ff.pix.red_in;
      for (int c = 0; c < 3; c++) begin
         cs_old[c] = cur_ff.row_first ? '0 : cs_x_ff[c*CSUM_W +: CSUM_W];
         rs_sub[c] = cur_ff.row_ge_k ? rs_rd_ff[c*8 +: 8] : 8'd0;
         new_cs[c] = cs_old[c] + {4'd0, pix_ch[c]} - {4'd0, rs_sub[c]};
         ws_old[c] = cur_ff.col_first ? '0 : wsum_ff[c];
         ws_sub[c] = cur_ff.col_ge_k ? cs_xk_ff[c*CSUM_W +: CSUM_W] : '0;
         new_ws[c] = ws_old[c] + {4'd0, new_cs[c]} - {4'd0, ws_sub[c]};
         rem_sh[c] = {rem_ff[c], quo_ff[c][WSUM_W-1]};
         if (rem_sh[c] >= {1'b0, cur_ff.count}) begin
            rem_in[c] = 8'(rem_sh[c] - {1'b0, cur_ff.count});
            quo_in[c] = {quo_ff[c][WSUM_W-2:0], 1'b1};
         end else begin
            rem_in[c] = rem_sh[c][7:0];
            quo_in[c] = {quo_ff[c][WSUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rs_rd_ff <= row_store[RS_AW'({head.slot, head.x})];
         cs_x_ff  <= column_sums[head.x];
         cs_xk_ff <= column_sums[head.xk];
      end
      if (load_sum) begin
         row_store[RS_AW'({cur_ff.slot, cur_ff.x})] <= {pix_ch[2], pix_ch[1], pix_ch[0]};
         column_sums[cur_ff.x] <= {new_cs[2], new_cs[1], new_cs[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
      for (int c = 0; c < 3; c++) begin
         if (load_sum) begin
            quo_ff[c] <= new_ws[c];
            rem_ff[c] <= 8'd0;
         end else if (div_step) begin
            quo_ff[c] <= quo_in[c];
            rem_ff[c] <= rem_in[c];
         end
      end
      if (load_sum) step_ff <= '0;
      else if (div_step) step_ff <= step_ff + 1'b1;
      if (load_rsp) begin
         rsp_data_ff.blue_out   <= quo_ff[0][7:0];
         rsp_data_ff.green_out  <= quo_ff[1][7:0];
         rsp_data_ff.red_out    <= quo_ff[2][7:0];
         rsp_data_ff.frame_last <= cur_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) wsum_ff[c] <= '0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (load_sum) begin
            for (int c = 0; c < 3; c++) wsum_ff[c] <= new_ws[c];
         end
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/forward_box_blur_rgb.sv -----
// Box blur of a BGR pixel stream fed in reverse raster order (last row first, each row right
// to left); each pixel gives one result, the truncating average of the clipped window that
// reaches right and down from it. The front end tracks row and column and classifies each
// pixel into a command, a two-entry queue buffers commands, and the back end updates the
// column sums (one memory, two read ports) and row store, then runs a radix-2 divider per
// channel, the three in step. Each pixel occupies the back end through a read, a sum update,
// 16 divide steps and an output load, and no new pixel is taken until its result is loaded,
// which a stalled output holds back. There is no clearing pass after reset: column sums read
// on the first row of a frame count as zero. Configuration writes restart the frame.
`default_nettype none
module forward_box_blur_rgb (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fbb_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fbb_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  fbb_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_data
);
   import fbb_pkg::*;

   cmd_type    cmd, head;
   logic       cmd_push, pop;
   q_stat_type q_stat;

   fbb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_stat    (q_stat),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   fbb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (pop),
      .head      (head),
      .stat      (q_stat)
   );

   fbb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

// ----- rtl/core/fbb_checker.sv -----
`default_nettype none
`include "forward_box_blur_rgb_defines.svh"
module fbb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input fbb_pkg::req_type       req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input fbb_pkg::rsp_type       rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input fbb_pkg::csr_index_type csr_index,
   input logic [15:0]            csr_data
);
   import fbb_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_valid, req_stall, req_data, csr_valid, csr_index, csr_data};

   `FBB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result transfer changed")
   `FBB_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_ready, "configuration port not ready")
   `FBB_ASSERT_NOW(a_reset_idle, clock, reset, $past(reset), !rsp_valid, "result shown straight after reset")
endmodule

bind forward_box_blur_rgb fbb_checker u_fbb_checker (.*);
`default_nettype wire
